[design/quaternion_arith_unit_core_macros.svh]
// Assertion macros for the quaternion arithmetic unit checker.
// No dependencies; included by the checker file.
`ifndef QUATERNION_ARITH_UNIT_CORE_MACROS_SVH
`define QUATERNION_ARITH_UNIT_CORE_MACROS_SVH

// check a property while out of reset
`define QAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define QAU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/qau_pkg.sv]
// Shared widths, codes, item type and saturation helper for the quaternion unit.
// No dependencies; used by every design module and the checker.
package qau_pkg;

  localparam int WORD_BITS      = 16;
  localparam int FRAC_BITS      = 12;
  localparam int LANES          = 4;
  localparam int PROD_BITS      = 2 * WORD_BITS;
  localparam int SUM_BITS       = PROD_BITS + 2;
  localparam int RND_BITS       = SUM_BITS - FRAC_BITS;
  localparam int RAD_BITS       = SUM_BITS;
  localparam int ROOT_BITS      = RAD_BITS / 2;
  localparam int REM_BITS       = ROOT_BITS + 3;
  localparam int LEN_BITS       = ROOT_BITS + 1;
  localparam int NUM_BITS       = WORD_BITS + FRAC_BITS;
  localparam int DREM_BITS      = LEN_BITS + 1;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES    = (ROOT_BITS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
  localparam int DIV_PER_STAGE  = 4;
  localparam int DIV_STAGES     = (NUM_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  localparam logic signed [SUM_BITS-1:0] WORD_MAX =
    SUM_BITS'((longint'(1) << (WORD_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] WORD_MIN = -WORD_MAX - SUM_BITS'(1);
  localparam logic signed [SUM_BITS-1:0] RND_HALF =
    SUM_BITS'(longint'(1) << (FRAC_BITS - 1));
  localparam logic [LEN_BITS-1:0] MAG_MAX = LEN_BITS'((longint'(1) << WORD_BITS) - 1);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [1:0] {
    OP_QMUL = 2'd0,
    OP_VMUL = 2'd1,
    OP_NORM = 2'd2,
    OP_CONJ = 2'd3
  } op_t;

  typedef struct packed {
    op_t                              op;
    logic [LANES-1:0]                 neg;
    logic [LANES-1:0][WORD_BITS-1:0]  mag_a;
    logic [LANES-1:0][WORD_BITS-1:0]  r;
    logic                             sat;
    logic                             zl;
  } item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] w;
    logic                 sat;
  } sat_t;

  function automatic sat_t sat_word(input logic signed [SUM_BITS-1:0] v);
    sat_t s;
    if (v > WORD_MAX) begin
      s.w   = WORD_MAX[WORD_BITS-1:0];
      s.sat = 1'b1;
    end else if (v < WORD_MIN) begin
      s.w   = WORD_MIN[WORD_BITS-1:0];
      s.sat = 1'b1;
    end else begin
      s.w   = v[WORD_BITS-1:0];
      s.sat = 1'b0;
    end
    return s;
  endfunction

endpackage

[design/qau_mult.sv]
// Front end: products, rounded sums, saturation, conjugate and sum of squares.
// Depends on qau_pkg. Three register stages.
module qau_mult (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                en,
  input  logic                                                in_v,
  input  logic [1:0]                                          in_op,
  input  logic [qau_pkg::LANES-1:0][qau_pkg::WORD_BITS-1:0]   in_a,
  input  logic [qau_pkg::LANES-1:0][qau_pkg::WORD_BITS-1:0]   in_b,
  output logic                                                out_v,
  output qau_pkg::item_t                                      out_item,
  output logic [qau_pkg::RAD_BITS-1:0]                        out_sumsq
);

  logic                                  v1_r;
  qau_pkg::op_t                          op1_r;
  logic signed [qau_pkg::PROD_BITS-1:0]  p1_r [qau_pkg::LANES][qau_pkg::LANES];
  logic [qau_pkg::PROD_BITS-1:0]         sq1_r [qau_pkg::LANES];
  logic [qau_pkg::LANES-1:0][qau_pkg::WORD_BITS-1:0] a1_r;

  logic signed [qau_pkg::SUM_BITS-1:0]   sum2 [qau_pkg::LANES];
  logic signed [qau_pkg::SUM_BITS-1:0]   rnd2 [qau_pkg::LANES];
  logic signed [qau_pkg::RND_BITS-1:0]   r2_nxt [qau_pkg::LANES];
  logic [qau_pkg::RAD_BITS-1:0]          ssq2_nxt;

  logic                                  v2_r;
  qau_pkg::op_t                          op2_r;
  logic signed [qau_pkg::RND_BITS-1:0]   r2_r [qau_pkg::LANES];
  logic [qau_pkg::RAD_BITS-1:0]          ssq2_r;
  logic [qau_pkg::LANES-1:0][qau_pkg::WORD_BITS-1:0] a2_r;

  qau_pkg::item_t                        item3_nxt;
  logic                                  v3_r;
  qau_pkg::item_t                        item3_r;
  logic [qau_pkg::RAD_BITS-1:0]          ssq3_r;

  function automatic logic signed [qau_pkg::SUM_BITS-1:0] ext(
    input logic signed [qau_pkg::PROD_BITS-1:0] p);
    return qau_pkg::SUM_BITS'(p);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= qau_pkg::op_t'(in_op);
      a1_r  <= in_a;
      for (int i = 0; i < qau_pkg::LANES; i++) begin
        sq1_r[i] <= $signed(in_a[i]) * $signed(in_a[i]);
        for (int j = 0; j < qau_pkg::LANES; j++) begin
          p1_r[i][j] <= $signed(in_a[i]) * $signed(in_b[j]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < qau_pkg::LANES; i++) begin
      sum2[i] = '0;
    end
    case (op1_r)
      qau_pkg::OP_QMUL: begin
        sum2[3] = ext(p1_r[3][3]) - ext(p1_r[0][0]) - ext(p1_r[1][1]) - ext(p1_r[2][2]);
        sum2[0] = ext(p1_r[0][3]) + ext(p1_r[3][0]) + ext(p1_r[1][2]) - ext(p1_r[2][1]);
        sum2[1] = ext(p1_r[1][3]) + ext(p1_r[3][1]) + ext(p1_r[2][0]) - ext(p1_r[0][2]);
        sum2[2] = ext(p1_r[2][3]) + ext(p1_r[3][2]) + ext(p1_r[0][1]) - ext(p1_r[1][0]);
      end
      qau_pkg::OP_VMUL: begin
        sum2[3] = -(ext(p1_r[0][0]) + ext(p1_r[1][1]) + ext(p1_r[2][2]));
        sum2[0] = ext(p1_r[0][3]) + ext(p1_r[2][1]) - ext(p1_r[1][2]);
        sum2[1] = ext(p1_r[1][3]) + ext(p1_r[0][2]) - ext(p1_r[2][0]);
        sum2[2] = ext(p1_r[2][3]) + ext(p1_r[1][0]) - ext(p1_r[0][1]);
      end
      default: begin
        for (int i = 0; i < qau_pkg::LANES; i++) begin
          sum2[i] = '0;
        end
      end
    endcase
    ssq2_nxt = '0;
    for (int i = 0; i < qau_pkg::LANES; i++) begin
      rnd2[i]   = sum2[i] + qau_pkg::RND_HALF;
      r2_nxt[i] = rnd2[i][qau_pkg::SUM_BITS-1:qau_pkg::FRAC_BITS];
      ssq2_nxt  = ssq2_nxt + qau_pkg::RAD_BITS'(sq1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      a2_r   <= a1_r;
      ssq2_r <= ssq2_nxt;
      for (int i = 0; i < qau_pkg::LANES; i++) begin
        r2_r[i] <= r2_nxt[i];
      end
    end
  end

  always_comb begin
    logic signed [qau_pkg::SUM_BITS-1:0] av;
    qau_pkg::sat_t                       s;
    item3_nxt     = '0;
    item3_nxt.op  = op2_r;
    for (int i = 0; i < qau_pkg::LANES; i++) begin
      av = qau_pkg::SUM_BITS'($signed(a2_r[i]));
      item3_nxt.neg[i]   = a2_r[i][qau_pkg::WORD_BITS-1];
      item3_nxt.mag_a[i] = a2_r[i][qau_pkg::WORD_BITS-1] ? -a2_r[i] : a2_r[i];
      case (op2_r)
        qau_pkg::OP_QMUL, qau_pkg::OP_VMUL: s = qau_pkg::sat_word(
                                              qau_pkg::SUM_BITS'(r2_r[i]));
        qau_pkg::OP_CONJ:                   s = qau_pkg::sat_word(
                                              (i == qau_pkg::LANES - 1) ? av : -av);
        default:                            s = '0;
      endcase
      item3_nxt.r[i] = s.w;
      item3_nxt.sat  = item3_nxt.sat | s.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item3_r <= item3_nxt;
      ssq3_r  <= ssq2_r;
    end
  end

  assign out_v     = v3_r;
  assign out_item  = item3_r;
  assign out_sumsq = ssq3_r;

endmodule

[design/qau_sqrt.sv]
// Pipelined rounded integer square root, two root bits per stage, item carried along.
// Depends on qau_pkg.
module qau_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_v,
  input  logic [qau_pkg::RAD_BITS-1:0]   in_rad,
  input  qau_pkg::item_t                 in_item,
  output logic                           out_v,
  output logic [qau_pkg::LEN_BITS-1:0]   out_root,
  output qau_pkg::item_t                 out_item
);

  localparam int LAST = qau_pkg::SQRT_STAGES - 1;

  typedef struct packed {
    logic [qau_pkg::RAD_BITS-1:0]  rad;
    logic [qau_pkg::REM_BITS-1:0]  rem;
    logic [qau_pkg::ROOT_BITS-1:0] root;
  } sq_st_t;

  sq_st_t         st_r [qau_pkg::SQRT_STAGES];
  logic           v_r  [qau_pkg::SQRT_STAGES];
  qau_pkg::item_t it_r [qau_pkg::SQRT_STAGES];

  function automatic sq_st_t sq_step(input sq_st_t s);
    sq_st_t                       t;
    logic [qau_pkg::REM_BITS-1:0] rem2;
    logic [qau_pkg::REM_BITS-1:0] trial;
    rem2  = {s.rem[qau_pkg::REM_BITS-3:0], s.rad[qau_pkg::RAD_BITS-1 -: 2]};
    trial = qau_pkg::REM_BITS'({s.root, 2'b01});
    t.rad = {s.rad[qau_pkg::RAD_BITS-3:0], 2'b00};
    if (rem2 >= trial) begin
      t.rem  = rem2 - trial;
      t.root = {s.root[qau_pkg::ROOT_BITS-2:0], 1'b1};
    end else begin
      t.rem  = rem2;
      t.root = {s.root[qau_pkg::ROOT_BITS-2:0], 1'b0};
    end
    return t;
  endfunction

  for (genvar s = 0; s < qau_pkg::SQRT_STAGES; s++) begin : g_stage
    sq_st_t         cur;
    logic           cur_v;
    qau_pkg::item_t cur_it;
    sq_st_t         st_nxt;

    if (s == 0) begin : g_first
      assign cur    = '{rad: in_rad, rem: '0, root: '0};
      assign cur_v  = in_v;
      assign cur_it = in_item;
    end else begin : g_next
      assign cur    = st_r[s-1];
      assign cur_v  = v_r[s-1];
      assign cur_it = it_r[s-1];
    end

    always_comb begin
      st_nxt = cur;
      for (int j = 0; j < qau_pkg::SQRT_PER_STAGE; j++) begin
        if (s * qau_pkg::SQRT_PER_STAGE + j < qau_pkg::ROOT_BITS) begin
          st_nxt = sq_step(st_nxt);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s] <= st_nxt;
        it_r[s] <= cur_it;
      end
    end
  end

  assign out_v    = v_r[LAST];
  assign out_item = it_r[LAST];
  assign out_root = (st_r[LAST].rem > qau_pkg::REM_BITS'(st_r[LAST].root)) ?
                    qau_pkg::LEN_BITS'(st_r[LAST].root) + qau_pkg::LEN_BITS'(1) :
                    qau_pkg::LEN_BITS'(st_r[LAST].root);

endmodule

[design/qau_div.sv]
// Pipelined four-lane restoring divider for normalization, four quotient bits per stage.
// Depends on qau_pkg. Dividend is |a| scaled plus half the divisor.
module qau_div (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               en,
  input  logic                                               in_v,
  input  logic [qau_pkg::LEN_BITS-1:0]                       in_den,
  input  qau_pkg::item_t                                     in_item,
  output logic                                               out_v,
  output logic [qau_pkg::LANES-1:0][qau_pkg::NUM_BITS-1:0]   out_q,
  output qau_pkg::item_t                                     out_item
);

  localparam int LAST = qau_pkg::DIV_STAGES - 1;

  typedef struct packed {
    logic [qau_pkg::NUM_BITS-1:0]  num;
    logic [qau_pkg::DREM_BITS-1:0] rem;
    logic [qau_pkg::NUM_BITS-1:0]  q;
  } dv_lane_t;

  typedef struct packed {
    logic [qau_pkg::LEN_BITS-1:0]        den;
    dv_lane_t [qau_pkg::LANES-1:0]       ln;
  } dv_st_t;

  dv_st_t         st_r [qau_pkg::DIV_STAGES];
  logic           v_r  [qau_pkg::DIV_STAGES];
  qau_pkg::item_t it_r [qau_pkg::DIV_STAGES];
  dv_st_t         st_in;

  function automatic dv_lane_t dv_step(input dv_lane_t l,
                                       input logic [qau_pkg::LEN_BITS-1:0] den);
    dv_lane_t                      t;
    logic [qau_pkg::DREM_BITS-1:0] rem2;
    rem2  = {l.rem[qau_pkg::DREM_BITS-2:0], l.num[qau_pkg::NUM_BITS-1]};
    t.num = {l.num[qau_pkg::NUM_BITS-2:0], 1'b0};
    if (rem2 >= qau_pkg::DREM_BITS'(den)) begin
      t.rem = rem2 - qau_pkg::DREM_BITS'(den);
      t.q   = {l.q[qau_pkg::NUM_BITS-2:0], 1'b1};
    end else begin
      t.rem = rem2;
      t.q   = {l.q[qau_pkg::NUM_BITS-2:0], 1'b0};
    end
    return t;
  endfunction

  always_comb begin
    st_in     = '0;
    st_in.den = in_den;
    for (int i = 0; i < qau_pkg::LANES; i++) begin
      st_in.ln[i].num = (qau_pkg::NUM_BITS'(in_item.mag_a[i]) << qau_pkg::FRAC_BITS) +
                        qau_pkg::NUM_BITS'(in_den >> 1);
    end
  end

  for (genvar s = 0; s < qau_pkg::DIV_STAGES; s++) begin : g_stage
    dv_st_t         cur;
    logic           cur_v;
    qau_pkg::item_t cur_it;
    dv_st_t         st_nxt;

    if (s == 0) begin : g_first
      assign cur    = st_in;
      assign cur_v  = in_v;
      assign cur_it = in_item;
    end else begin : g_next
      assign cur    = st_r[s-1];
      assign cur_v  = v_r[s-1];
      assign cur_it = it_r[s-1];
    end

    always_comb begin
      st_nxt = cur;
      for (int j = 0; j < qau_pkg::DIV_PER_STAGE; j++) begin
        if (s * qau_pkg::DIV_PER_STAGE + j < qau_pkg::NUM_BITS) begin
          for (int i = 0; i < qau_pkg::LANES; i++) begin
            st_nxt.ln[i] = dv_step(st_nxt.ln[i], cur.den);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s] <= st_nxt;
        it_r[s] <= cur_it;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < qau_pkg::LANES; i++) begin
      out_q[i] = st_r[LAST].ln[i].q;
    end
  end

  assign out_v    = v_r[LAST];
  assign out_item = it_r[LAST];

endmodule

[design/quaternion_arith_unit_core.sv]
// Top level of the quaternion arithmetic unit: product, normalize, conjugate, magnitude.
// Depends on qau_pkg, qau_mult, qau_sqrt and qau_div.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------------------
//   in_      | input     | in_valid/in_stall  | req_type, a_x..a_w, b_x..b_w
//   out_     | output    | out_valid/out_stall| r_x..r_w, magnitude, status
//
// One item enters per cycle while in_stall is low.
// The item passes 33 register stages: two square roots (9 stages each, 2 root bits
// per stage), the divider (7 stages, 4 quotient bits per stage) and 8 arithmetic stages.
// Reset (rst_n low, synchronous) clears every stage valid, the output and skid.
// A stall on out_ holds the result; one more item drains into the skid register,
// then the pipeline freezes and in_stall rises until the skid empties.
module quaternion_arith_unit_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_req_type,
  input  logic signed [qau_pkg::WORD_BITS-1:0]    in_a_x,
  input  logic signed [qau_pkg::WORD_BITS-1:0]    in_a_y,
  input  logic signed [qau_pkg::WORD_BITS-1:0]    in_a_z,
  input  logic signed [qau_pkg::WORD_BITS-1:0]    in_a_w,
  input  logic signed [qau_pkg::WORD_BITS-1:0]    in_b_x,
  input  logic signed [qau_pkg::WORD_BITS-1:0]    in_b_y,
  input  logic signed [qau_pkg::WORD_BITS-1:0]    in_b_z,
  input  logic signed [qau_pkg::WORD_BITS-1:0]    in_b_w,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [qau_pkg::WORD_BITS-1:0]    out_r_x,
  output logic signed [qau_pkg::WORD_BITS-1:0]    out_r_y,
  output logic signed [qau_pkg::WORD_BITS-1:0]    out_r_z,
  output logic signed [qau_pkg::WORD_BITS-1:0]    out_r_w,
  output logic [qau_pkg::WORD_BITS-1:0]           out_magnitude,
  output logic [1:0]                              out_status
);

  typedef struct packed {
    logic [qau_pkg::LANES-1:0][qau_pkg::WORD_BITS-1:0] r;
    logic [qau_pkg::WORD_BITS-1:0]                     mag;
    logic [1:0]                                        status;
  } res_t;

  logic                                               en;
  logic [qau_pkg::LANES-1:0][qau_pkg::WORD_BITS-1:0]  a_pk;
  logic [qau_pkg::LANES-1:0][qau_pkg::WORD_BITS-1:0]  b_pk;

  logic                                               m_v;
  qau_pkg::item_t                                     m_item;
  logic [qau_pkg::RAD_BITS-1:0]                       m_sumsq;

  logic                                               s1_v;
  logic [qau_pkg::LEN_BITS-1:0]                       s1_root;
  qau_pkg::item_t                                     s1_item;
  qau_pkg::item_t                                     d_in_item;

  logic                                               d_v;
  logic [qau_pkg::LANES-1:0][qau_pkg::NUM_BITS-1:0]   d_q;
  qau_pkg::item_t                                     d_item;

  qau_pkg::item_t                                     e_item_nxt;
  logic                                               e_v_r;
  qau_pkg::item_t                                     e_item_r;

  logic                                               f_v_r;
  qau_pkg::item_t                                     f_item_r;
  logic [qau_pkg::PROD_BITS-1:0]                      f_sq_r [qau_pkg::LANES];

  logic [qau_pkg::RAD_BITS-1:0]                       g_sum_nxt;
  logic                                               g_v_r;
  qau_pkg::item_t                                     g_item_r;
  logic [qau_pkg::RAD_BITS-1:0]                       g_sum_r;

  logic                                               s2_v;
  logic [qau_pkg::LEN_BITS-1:0]                       s2_root;
  qau_pkg::item_t                                     s2_item;

  res_t                                               t_nxt;
  logic                                               t_v_r;
  res_t                                               t_r;

  logic                                               out_ready;
  logic                                               out_v_r;
  res_t                                               out_r;
  logic                                               skid_v_r;
  res_t                                               skid_r;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;
  assign a_pk     = {in_a_w, in_a_z, in_a_y, in_a_x};
  assign b_pk     = {in_b_w, in_b_z, in_b_y, in_b_x};

  qau_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (in_valid),
    .in_op     (in_req_type),
    .in_a      (a_pk),
    .in_b      (b_pk),
    .out_v     (m_v),
    .out_item  (m_item),
    .out_sumsq (m_sumsq)
  );

  qau_sqrt u_len (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (m_v),
    .in_rad   (m_sumsq),
    .in_item  (m_item),
    .out_v    (s1_v),
    .out_root (s1_root),
    .out_item (s1_item)
  );

  always_comb begin
    d_in_item    = s1_item;
    d_in_item.zl = (s1_item.op == qau_pkg::OP_NORM) && (s1_root == '0);
  end

  qau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (s1_v),
    .in_den   (s1_root),
    .in_item  (d_in_item),
    .out_v    (d_v),
    .out_q    (d_q),
    .out_item (d_item)
  );

  always_comb begin
    logic signed [qau_pkg::SUM_BITS-1:0] qs;
    qau_pkg::sat_t                       s;
    e_item_nxt = d_item;
    for (int i = 0; i < qau_pkg::LANES; i++) begin
      qs = qau_pkg::SUM_BITS'(d_q[i]);
      s  = qau_pkg::sat_word(d_item.neg[i] ? -qs : qs);
      if (d_item.op == qau_pkg::OP_NORM) begin
        if (d_item.zl) begin
          e_item_nxt.r[i] = '0;
        end else begin
          e_item_nxt.r[i] = s.w;
          e_item_nxt.sat  = e_item_nxt.sat | s.sat;
        end
      end
    end
  end

  always_comb begin
    g_sum_nxt = '0;
    for (int i = 0; i < qau_pkg::LANES; i++) begin
      g_sum_nxt = g_sum_nxt + qau_pkg::RAD_BITS'(f_sq_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= d_v;
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_item_r <= e_item_nxt;
      f_item_r <= e_item_r;
      for (int i = 0; i < qau_pkg::LANES; i++) begin
        f_sq_r[i] <= $signed(e_item_r.r[i]) * $signed(e_item_r.r[i]);
      end
      g_item_r <= f_item_r;
      g_sum_r  <= g_sum_nxt;
    end
  end

  qau_sqrt u_mag (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (g_v_r),
    .in_rad   (g_sum_r),
    .in_item  (g_item_r),
    .out_v    (s2_v),
    .out_root (s2_root),
    .out_item (s2_item)
  );

  always_comb begin
    logic over;
    over    = s2_root > qau_pkg::MAG_MAX;
    t_nxt.r = s2_item.r;
    t_nxt.mag = over ? qau_pkg::MAG_MAX[qau_pkg::WORD_BITS-1:0] :
                       s2_root[qau_pkg::WORD_BITS-1:0];
    if (s2_item.zl) begin
      t_nxt.status = qau_pkg::ST_ZERO;
    end else if (s2_item.sat || over) begin
      t_nxt.status = qau_pkg::ST_SAT;
    end else begin
      t_nxt.status = qau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else if (en) begin
      t_v_r <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
    end
  end

  assign out_ready = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= t_v_r;
      end
    end else if (t_v_r && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_r <= skid_v_r ? skid_r : t_r;
    end else if (t_v_r && en) begin
      skid_r <= t_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_r_x       = out_r.r[0];
  assign out_r_y       = out_r.r[1];
  assign out_r_z       = out_r.r[2];
  assign out_r_w       = out_r.r[3];
  assign out_magnitude = out_r.mag;
  assign out_status    = out_r.status;

endmodule

[design/qau_chk.sv]
// Port-level checker for the quaternion arithmetic unit, bound to the top level.
// Depends on qau_pkg and quaternion_arith_unit_core_macros.svh.
`include "quaternion_arith_unit_core_macros.svh"

module qau_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [qau_pkg::WORD_BITS-1:0]  out_r_x,
  input logic signed [qau_pkg::WORD_BITS-1:0]  out_r_y,
  input logic signed [qau_pkg::WORD_BITS-1:0]  out_r_z,
  input logic signed [qau_pkg::WORD_BITS-1:0]  out_r_w,
  input logic [qau_pkg::WORD_BITS-1:0]         out_magnitude,
  input logic [1:0]                            out_status
);

  `QAU_ASSERT_RST(a_rst_clears, !rst_n |=> !out_valid && !in_stall, "reset left an item or stall")
  `QAU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_r_x) && $stable(out_r_y) && $stable(out_r_z) && $stable(out_r_w) && $stable(out_magnitude) && $stable(out_status), "stalled item changed")
  `QAU_ASSERT(a_status_code, out_valid |-> out_status <= qau_pkg::ST_SAT, "undefined status code")
  `QAU_ASSERT(a_zero_len, out_valid && out_status == qau_pkg::ST_ZERO |-> out_magnitude == '0 && out_r_x == '0 && out_r_y == '0 && out_r_z == '0 && out_r_w == '0, "zero-length item not zero")

endmodule

bind quaternion_arith_unit_core qau_chk u_qau_chk (.*);

[tb/sv/quaternion_arith_unit_core_tb.sv]
// Testbench for quaternion_arith_unit_core: drives product, vector, normalize and conjugate
// requests and checks every result against an in-file fixed-point predictor.
// Depends on qau_pkg and the quaternion_arith_unit_core RTL.
`timescale 1ns / 1ps

module quaternion_arith_unit_core_tb;

  typedef struct {
    qau_pkg::op_t       op;
    logic signed [15:0] a [4];
    logic signed [15:0] b [4];
  } req_item_t;

  typedef struct {
    logic signed [15:0] r [4];
    logic [15:0]        mag;
    logic [1:0]         status;
  } quat_result_t;

  localparam longint CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic signed [15:0] in_a_x = '0, in_a_y = '0, in_a_z = '0, in_a_w = '0;
  logic signed [15:0] in_b_x = '0, in_b_y = '0, in_b_z = '0, in_b_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_r_x, out_r_y, out_r_z, out_r_w;
  logic [15:0] out_magnitude;
  logic [1:0] out_status;

  req_item_t    pending_reqs [$];
  quat_result_t expected_results [$];
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  error_count = 0;
  longint cycle_count = 0;

  quaternion_arith_unit_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z), .in_a_w(in_a_w),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z), .in_b_w(in_b_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_r_x(out_r_x), .out_r_y(out_r_y), .out_r_z(out_r_z), .out_r_w(out_r_w),
    .out_magnitude(out_magnitude), .out_status(out_status)
  );

  always #5 clk = ~clk;

  function automatic longint rounded_length(input longint v [4]);
    longint unsigned acc, r, bitv, s;
    acc = 0;
    r = 0;
    for (int i = 0; i < 4; i++) acc += longint'(v[i] * v[i]);
    s = acc;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= r + bitv) begin
        s -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    if (acc - r * r > r) r++;
    return longint'(r);
  endfunction

  function automatic quat_result_t predict_quat(input req_item_t q);
    quat_result_t res;
    longint ax, ay, az, aw, bx, by, bz, bw, len, n, quo;
    longint s [4];
    longint v [4];
    logic sat, zero_len;
    ax = q.a[0]; ay = q.a[1]; az = q.a[2]; aw = q.a[3];
    bx = q.b[0]; by = q.b[1]; bz = q.b[2]; bw = q.b[3];
    sat = 1'b0;
    zero_len = 1'b0;
    case (q.op)
      qau_pkg::OP_QMUL: begin
        s[3] = aw * bw - ax * bx - ay * by - az * bz;
        s[0] = ax * bw + aw * bx + ay * bz - az * by;
        s[1] = ay * bw + aw * by + az * bx - ax * bz;
        s[2] = az * bw + aw * bz + ax * by - ay * bx;
        for (int i = 0; i < 4; i++) v[i] = (s[i] + 2048) >>> 12;
      end
      qau_pkg::OP_VMUL: begin
        s[3] = -(bx * ax) - by * ay - bz * az;
        s[0] = bw * ax + by * az - bz * ay;
        s[1] = bw * ay + bz * ax - bx * az;
        s[2] = bw * az + bx * ay - by * ax;
        for (int i = 0; i < 4; i++) v[i] = (s[i] + 2048) >>> 12;
      end
      qau_pkg::OP_NORM: begin
        s[0] = ax; s[1] = ay; s[2] = az; s[3] = aw;
        len = rounded_length(s);
        if (len == 0) begin
          zero_len = 1'b1;
          for (int i = 0; i < 4; i++) v[i] = 0;
        end else begin
          for (int i = 0; i < 4; i++) begin
            n = (s[i] < 0 ? -s[i] : s[i]) << 12;
            quo = (n + len / 2) / len;
            v[i] = s[i] < 0 ? -quo : quo;
          end
        end
      end
      default: begin
        v[0] = -ax; v[1] = -ay; v[2] = -az; v[3] = aw;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      if (v[i] > 32767) begin
        v[i] = 32767;
        sat = 1'b1;
      end else if (v[i] < -32768) begin
        v[i] = -32768;
        sat = 1'b1;
      end
      res.r[i] = v[i][15:0];
    end
    len = rounded_length(v);
    if (len > 65535) begin
      len = 65535;
      sat = 1'b1;
    end
    res.mag = len[15:0];
    res.status = zero_len ? qau_pkg::ST_ZERO : (sat ? qau_pkg::ST_SAT : qau_pkg::ST_OK);
    return res;
  endfunction

  function automatic logic signed [15:0] pick_component();
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind < 4) return 16'($urandom);
    if (kind < 8) return 16'($urandom_range(16384) - 8192);
    case ($urandom_range(4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh1000;
      3: return -16'sh1000;
      default: return 16'sh0000;
    endcase
  endfunction

  task automatic add_req(input qau_pkg::op_t op, input logic signed [15:0] ax, ay, az, aw,
                         input logic signed [15:0] bx, by, bz, bw);
    req_item_t q;
    q.op = op;
    q.a[0] = ax; q.a[1] = ay; q.a[2] = az; q.a[3] = aw;
    q.b[0] = bx; q.b[1] = by; q.b[2] = bz; q.b[3] = bw;
    pending_reqs.push_back(q);
  endtask

  task automatic add_random_reqs(input int count);
    req_item_t q;
    for (int k = 0; k < count; k++) begin
      q.op = qau_pkg::op_t'($urandom_range(3));
      for (int i = 0; i < 4; i++) begin
        q.a[i] = pick_component();
        q.b[i] = pick_component();
      end
      pending_reqs.push_back(q);
    end
  endtask

  task automatic drain_phase();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // hold the payload while stalled, otherwise advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_item_t q;
        q = pending_reqs.pop_front();
        expected_results.push_back(predict_quat(q));
        in_valid    <= 1'b1;
        in_req_type <= q.op;
        in_a_x <= q.a[0]; in_a_y <= q.a[1]; in_a_z <= q.a[2]; in_a_w <= q.a[3];
        in_b_x <= q.b[0]; in_b_y <= q.b[1]; in_b_z <= q.b[2]; in_b_w <= q.b[3];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation waiting");
        error_count++;
      end else begin
        quat_result_t e;
        e = expected_results.pop_front();
        if (out_r_x !== e.r[0]) begin
          $error("r_x expected %0d actual %0d", e.r[0], out_r_x);
          error_count++;
        end
        if (out_r_y !== e.r[1]) begin
          $error("r_y expected %0d actual %0d", e.r[1], out_r_y);
          error_count++;
        end
        if (out_r_z !== e.r[2]) begin
          $error("r_z expected %0d actual %0d", e.r[2], out_r_z);
          error_count++;
        end
        if (out_r_w !== e.r[3]) begin
          $error("r_w expected %0d actual %0d", e.r[3], out_r_w);
          error_count++;
        end
        if (out_magnitude !== e.mag) begin
          $error("magnitude expected %0d actual %0d", e.mag, out_magnitude);
          error_count++;
        end
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 38;
    recv_idle_pct = 80;
    add_req(qau_pkg::OP_QMUL, 16'sh1000, 0, 0, 16'sh1000, 0, 16'sh1000, 0, 16'sh1000);
    add_req(qau_pkg::OP_QMUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
            16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    add_req(qau_pkg::OP_QMUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
            16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    add_req(qau_pkg::OP_QMUL, 1, -1, 1, -1, 16'sh0800, 16'sh0800, -16'sh0800, 16'sh0800);
    add_req(qau_pkg::OP_VMUL, 16'sh1000, 16'sh2000, -16'sh1000, 16'sh7fff,
            16'sh1000, 0, 16'sh1000, 16'sh1000);
    add_req(qau_pkg::OP_VMUL, 16'sh8000, 16'sh8000, 16'sh8000, 0,
            16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    add_req(qau_pkg::OP_VMUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
            16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff);
    add_req(qau_pkg::OP_NORM, 0, 0, 0, 0, 16'sh7fff, 1, 2, 3);
    add_req(qau_pkg::OP_NORM, 16'sh3000, 16'sh4000, 0, 0, 0, 0, 0, 0);
    add_req(qau_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
    add_req(qau_pkg::OP_NORM, -1, 1, -1, 1, 0, 0, 0, 0);
    add_req(qau_pkg::OP_NORM, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0);
    add_req(qau_pkg::OP_NORM, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0);
    add_req(qau_pkg::OP_NORM, 0, 0, 0, -16'sh0003, 0, 0, 0, 0);
    add_req(qau_pkg::OP_CONJ, 16'sh8000, 16'sh7fff, 0, 16'sh8000, 0, 0, 0, 0);
    add_req(qau_pkg::OP_CONJ, 16'sh1000, -16'sh1000, 16'sh8000, 16'sh7fff, 1, 1, 1, 1);
    add_req(qau_pkg::OP_CONJ, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0);
    add_req(qau_pkg::OP_CONJ, 0, 0, 0, 0, 0, 0, 0, 0);
    add_random_reqs(330);
    drain_phase();
    send_idle_pct = 80;
    recv_idle_pct = 38;
    add_random_reqs(350);
    drain_phase();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_reqs(350);
    drain_phase();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
